// ----- hw/rtl/i2cm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, codes and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int HALF_W      = 16;
    localparam int POLL_W      = 4;
    localparam int BIT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = 16'd10;
    localparam logic [POLL_W-1:0]    ACK_POLL_RESET    = 4'd5;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE     = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL    = 2'd1;

    // Command codes as they arrive in the kind field.
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_ACK_LOW,
        PH_ACK_POLL,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_RA_LOW,
        PH_RA_HIGH
    } t_phase;

    // One classified tick as it travels through the queue.
    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
        logic              send_ack;
        logic              sda_in;
    } t_item;

    // One result of one tick.
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_missing;
    } t_result;

    function automatic t_cmd classify(input logic [KIND_W-1:0] kind);
        t_cmd cmd;
        unique case (kind)
            KIND_START: cmd = CMD_START;
            KIND_STOP:  cmd = CMD_STOP;
            KIND_WRITE: cmd = CMD_WRITE;
            KIND_READ:  cmd = CMD_READ;
            default:    cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/i2cm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Valid/ready interfaces for ticks in, results out and register writes.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, kind, data, send_ack, sda_in, input ready);
    modport sink   (input valid, kind, data, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_missing, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_missing, output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/i2cm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts ticks, decodes the command kind and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [2:0]           i_kind,
    input  wire  [7:0]           i_data,
    input  wire                  i_send_ack,
    input  wire                  i_sda_in,
    output i2cm_pkg::t_item      o_head,
    output logic                 o_head_valid,
    input  wire                  i_pop
);
    import i2cm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    t_item              item;

    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    always_comb begin
        item.cmd      = classify(i_kind);
        item.data     = i_data;
        item.send_ack = i_send_ack;
        item.sda_in   = i_sda_in;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/i2cm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master back end
// Bus phase state machine, configuration registers and result register.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  i2cm_pkg::t_item      i_item,
    input  wire                  i_item_valid,
    output logic                 o_pop,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data,
    output i2cm_pkg::t_result    o_result,
    output logic                 o_result_valid,
    input  wire                  i_result_ready
);
    import i2cm_pkg::*;

    logic [HALF_W-1:0]    r_half;
    logic [POLL_W-1:0]    r_poll_limit;

    t_phase               r_phase,      n_phase;
    logic [BIT_IDX_W-1:0] r_bit_index,  n_bit_index;
    logic [BYTE_W-1:0]    r_shift,      n_shift;
    logic [HALF_W-1:0]    r_wait,       n_wait;
    logic [POLL_W-1:0]    r_poll,       n_poll;
    logic                 r_scl,        n_scl;
    logic                 r_sda,        n_sda;
    logic                 r_ack_choice, n_ack_choice;
    logic                 r_ack_miss,   n_ack_miss;
    logic [BYTE_W-1:0]    r_rx_byte,    n_rx_byte;
    logic                 done;

    t_result              r_result;
    logic                 r_result_valid;

    logic [HALF_W-1:0]    half_eff;
    logic [POLL_W-1:0]    limit_eff;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [POLL_W-1:0]    poll_inc;
    logic [BYTE_W-1:0]    rd_shift;

    // A new tick is taken whenever the result register is free or drains now.
    assign o_pop          = i_item_valid && (!r_result_valid || i_result_ready);
    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

    assign half_eff  = (r_half == '0) ? HALF_W'(1) : r_half;
    assign limit_eff = (r_poll_limit == '0) ? POLL_W'(1) : r_poll_limit;
    assign bit_inc   = r_bit_index + BIT_IDX_W'(1);
    assign poll_inc  = r_poll + POLL_W'(1);
    assign rd_shift  = {r_shift[BYTE_W-2:0], i_item.sda_in};

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_wait       = r_wait;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_choice = r_ack_choice;
        n_ack_miss   = r_ack_miss;
        n_rx_byte    = r_rx_byte;
        done         = 1'b0;

        if (r_phase == PH_IDLE) begin
            unique case (i_item.cmd)
                CMD_START: begin
                    n_phase = PH_START_A;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_wait  = half_eff;
                end
                CMD_STOP: begin
                    n_phase = PH_STOP_A;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                    n_wait  = half_eff;
                end
                CMD_WRITE: begin
                    n_shift     = i_item.data;
                    n_bit_index = '0;
                    n_phase     = PH_WR_LOW;
                    n_scl       = 1'b0;
                    n_wait      = half_eff;
                end
                CMD_READ: begin
                    n_shift      = '0;
                    n_bit_index  = '0;
                    n_ack_choice = i_item.send_ack;
                    n_phase      = PH_RD_LOW;
                    n_scl        = 1'b0;
                    n_sda        = 1'b1;
                    n_wait       = half_eff;
                end
                default: begin
                end
            endcase
        end else if (r_wait > HALF_W'(1)) begin
            n_wait = r_wait - HALF_W'(1);
        end else begin
            // Last tick of the phase: drive the next phase's levels.
            n_wait = half_eff;
            unique case (r_phase)
                PH_START_A: begin
                    n_phase = PH_START_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_STOP_A: begin
                    n_phase = PH_STOP_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = r_shift[BYTE_W-1];
                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                end
                PH_WR_HIGH: begin
                    n_bit_index = bit_inc;
                    n_scl       = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_phase = PH_ACK_LOW;
                        n_sda   = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                    end
                end
                PH_ACK_LOW: begin
                    n_poll  = '0;
                    n_phase = PH_ACK_POLL;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_ACK_POLL: begin
                    if (!i_item.sda_in) begin
                        n_ack_miss = 1'b0;
                        n_scl      = 1'b0;
                        done       = 1'b1;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= limit_eff) begin
                            n_ack_miss = 1'b1;
                            n_scl      = 1'b0;
                            done       = 1'b1;
                        end else begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                    end
                end
                PH_RD_LOW: begin
                    n_phase = PH_RD_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_RD_HIGH: begin
                    n_shift     = rd_shift;
                    n_bit_index = bit_inc;
                    n_scl       = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_rx_byte = rd_shift;
                        n_phase   = PH_RA_LOW;
                        n_sda     = !r_ack_choice;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_sda   = 1'b1;
                    end
                end
                PH_RA_LOW: begin
                    n_phase = PH_RA_HIGH;
                    n_scl   = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                n_phase = PH_IDLE;
                n_wait  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_PERIOD_RESET;
            r_poll_limit <= ACK_POLL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_half       <= i_cfg_data[HALF_W-1:0];
                CFG_ACK_POLL:    r_poll_limit <= i_cfg_data[POLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_wait       <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_choice <= 1'b0;
            r_ack_miss   <= 1'b0;
            r_rx_byte    <= '0;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_wait       <= n_wait;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_choice <= n_ack_choice;
            r_ack_miss   <= n_ack_miss;
            r_rx_byte    <= n_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result.scl_out     <= n_scl;
            r_result.sda_out     <= n_sda;
            r_result.busy_res    <= (n_phase != PH_IDLE);
            r_result.done_res    <= done;
            r_result.read_data   <= n_rx_byte;
            r_result.ack_missing <= n_ack_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (o_pop) begin
            r_result_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_result_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/i2c_master_bit_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master: start, stop, write byte and read byte commands.
// ----------------------------------------------------------------------------
// Usage: every transfer on i_in is one clock tick of the bus engine and
// carries a command kind, a write byte, the read acknowledge choice and the
// sampled SDA level. Every accepted tick yields exactly one transfer on o_out
// with the SCL and SDA drive levels, busy and done flags, the last read byte
// and the acknowledge status of the last write. Commands are only taken while
// the engine is idle; a command given while busy is ignored.
// Registers are written on i_cfg (index 0 half period, index 1 acknowledge
// poll limit); the port is always ready and must only be used while idle.
// A tick is queued at the edge that accepts it; the engine takes it from
// the queue once the result register is free or draining, and the result
// register shows its result from then on. Throughput is one tick per cycle
// while the receiver keeps up, set by the single-step phase state machine.
// Reset puts the engine idle with both lines released, the half period at
// 10 ticks and the poll limit at 5. When the receiver stalls, the result
// register holds its transfer, the queue fills and i_in.ready drops once
// DEPTH ticks are waiting.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_out,
    i2cm_cfg_if.sink    i_cfg
);
    import i2cm_pkg::*;

    t_item   head;
    logic    head_valid;
    logic    pop;
    t_result result;
    logic    result_valid;

    // Front end: decodes the kind field and buffers ticks so the input side
    // keeps flowing while the output side is stalled.
    i2cm_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_kind       (i_in.kind),
        .i_data       (i_in.data),
        .i_send_ack   (i_in.send_ack),
        .i_sda_in     (i_in.sda_in),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    // Back end: advances the bus phase machine once per popped tick and
    // registers the result for the output channel.
    i2cm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head),
        .i_item_valid   (head_valid),
        .o_pop          (pop),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_result       (result),
        .o_result_valid (result_valid),
        .i_result_ready (o_out.ready)
    );

    // Register writes complete in the cycle they are offered.
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = result_valid;
    assign o_out.scl_out     = result.scl_out;
    assign o_out.sda_out     = result.sda_out;
    assign o_out.busy_res    = result.busy_res;
    assign o_out.done_res    = result.done_res;
    assign o_out.read_data   = result.read_data;
    assign o_out.ack_missing = result.ack_missing;

endmodule
`default_nettype wire

// ----- hw/rtl/i2cm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_busy_res,
    input wire       i_done_res,
    input wire [7:0] i_read_data
);
    logic [3:0] r_outstanding;
    logic       r_prev_busy;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_prev_busy   <= 1'b0;
        end else begin
            if (in_xfer && !out_xfer) begin
                r_outstanding <= r_outstanding + 4'd1;
            end else if (!in_xfer && out_xfer) begin
                r_outstanding <= r_outstanding - 4'd1;
            end
            if (out_xfer) begin
                r_prev_busy <= i_busy_res;
            end
        end
    end

    // A stalled result keeps its read byte.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_read_data))
        else $error("read_data changed while the result was stalled");

    // Every result belongs to a tick taken earlier.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_outstanding != 4'd0))
        else $error("result shown without an outstanding tick");

    // A finished command leaves the engine idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |-> !i_busy_res)
        else $error("done and busy in the same result");

    // Completion only follows a busy tick.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && i_done_res) |-> r_prev_busy)
        else $error("done without a preceding busy result");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_busy_res  (o_out.busy_res),
    .i_done_res  (o_out.done_res),
    .i_read_data (o_out.read_data)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives clock ticks carrying commands and SDA samples into the engine and
// checks every per-tick bus result against a cycle-true engine model kept
// here, under random source gaps, sink stalls and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int CMDS_PER_PHASE = 3;

    // Kind codes that the package does not name: a plain tick and the top
    // of the unused range.
    localparam logic [KIND_W-1:0] KIND_TICK = '0;
    localparam logic [KIND_W-1:0] KIND_TOP  = '1;

    // How the SDA samples of a command's ticks are shaped.
    typedef enum int {
        SDA_HIGH,
        SDA_LOW,
        SDA_RANDOM,
        SDA_MOSTLY_HIGH
    } t_sda_mode;

    // One clock tick as it is offered to the engine.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              send_ack;
        logic              sda_in;
    } t_bus_tick;

    logic i_clk;
    logic i_rst_n;

    i2cm_in_if  tick_if ();
    i2cm_out_if res_if ();
    i2cm_cfg_if reg_if ();

    i2c_master_bit_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (res_if),
        .i_cfg   (reg_if)
    );

    // Ticks waiting to be offered, and the bus results that accepted ticks
    // are expected to produce, oldest first.
    t_bus_tick pending_ticks[$];
    t_result   expected_bus[$];

    int  mismatches;
    int  cycle_count;
    bit  idling;
    int  send_gap;
    int  sink_stall;

    t_bus_tick offered_tick;

    // Shadow of the engine: register settings and bus state.
    logic [HALF_W-1:0]    cfg_half;
    logic [POLL_W-1:0]    cfg_polls;
    t_phase               eng_phase;
    logic [BIT_IDX_W-1:0] eng_bits;
    logic [BYTE_W-1:0]    eng_shift;
    logic [BYTE_W-1:0]    eng_rx;
    logic [HALF_W-1:0]    eng_wait;
    logic [POLL_W-1:0]    eng_polls;
    logic                 eng_scl;
    logic                 eng_sda;
    logic                 eng_ack_choice;
    logic                 eng_nack;

    // ------------------------------------------------------------------------
    // Engine model
    // ------------------------------------------------------------------------

    // Enters a bus phase: sets both line levels and reloads the hold counter.
    // A zero half period holds each phase for a single tick.
    function automatic void enter_phase(input t_phase nxt, input logic scl,
                                        input logic sda);
        eng_phase = nxt;
        eng_scl   = scl;
        eng_sda   = sda;
        eng_wait  = (cfg_half == '0) ? HALF_W'(1) : cfg_half;
    endfunction

    // Runs on the last tick of a phase. Returns 1 when the command is over.
    function automatic logic advance_phase(input logic sda);
        logic [POLL_W-1:0] limit;
        logic              ends;
        ends  = 1'b0;
        limit = (cfg_polls == '0) ? POLL_W'(1) : cfg_polls;
        case (eng_phase)
            PH_START_A: enter_phase(PH_START_B, 1'b1, 1'b0);
            PH_STOP_A:  enter_phase(PH_STOP_B, 1'b1, 1'b1);
            PH_WR_LOW: begin
                // The data bit appears together with the SCL rise.
                enter_phase(PH_WR_HIGH, 1'b1, eng_shift[BYTE_W-1]);
                eng_shift = eng_shift << 1;
            end
            PH_WR_HIGH: begin
                eng_bits = eng_bits + 1'b1;
                if (eng_bits >= BITS_PER_BYTE) begin
                    enter_phase(PH_ACK_LOW, 1'b0, 1'b1);
                end else begin
                    enter_phase(PH_WR_LOW, 1'b0, eng_sda);
                end
            end
            PH_ACK_LOW: begin
                eng_polls = '0;
                enter_phase(PH_ACK_POLL, 1'b1, 1'b1);
            end
            PH_ACK_POLL: begin
                if (!sda) begin
                    // Slave pulled SDA low: the write ends right here.
                    eng_nack = 1'b0;
                    eng_scl  = 1'b0;
                    ends     = 1'b1;
                end else begin
                    eng_polls = eng_polls + 1'b1;
                    if (eng_polls >= limit) begin
                        eng_nack = 1'b1;
                        eng_scl  = 1'b0;
                        ends     = 1'b1;
                    end else begin
                        enter_phase(PH_ACK_POLL, 1'b1, 1'b1);
                    end
                end
            end
            PH_RD_LOW: enter_phase(PH_RD_HIGH, 1'b1, 1'b1);
            PH_RD_HIGH: begin
                eng_shift = {eng_shift[BYTE_W-2:0], sda};
                eng_bits  = eng_bits + 1'b1;
                if (eng_bits >= BITS_PER_BYTE) begin
                    eng_rx = eng_shift;
                    enter_phase(PH_RA_LOW, 1'b0, !eng_ack_choice);
                end else begin
                    enter_phase(PH_RD_LOW, 1'b0, 1'b1);
                end
            end
            PH_RA_LOW: enter_phase(PH_RA_HIGH, 1'b1, eng_sda);
            default:   ends = 1'b1;
        endcase
        return ends;
    endfunction

    // Advances the shadow engine by one accepted tick and returns the bus
    // result that tick must produce.
    function automatic t_result predict_tick(input t_bus_tick t);
        t_result r;
        logic    finished;
        finished = 1'b0;
        if (eng_phase == PH_IDLE) begin
            case (t.kind)
                KIND_START: enter_phase(PH_START_A, 1'b1, 1'b1);
                KIND_STOP:  enter_phase(PH_STOP_A, 1'b1, 1'b0);
                KIND_WRITE: begin
                    eng_shift = t.data;
                    eng_bits  = '0;
                    enter_phase(PH_WR_LOW, 1'b0, eng_sda);
                end
                KIND_READ: begin
                    eng_shift      = '0;
                    eng_bits       = '0;
                    eng_ack_choice = t.send_ack;
                    enter_phase(PH_RD_LOW, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end else if (eng_wait > 1) begin
            eng_wait = eng_wait - 1'b1;
        end else if (advance_phase(t.sda_in)) begin
            eng_phase = PH_IDLE;
            eng_wait  = '0;
            finished  = 1'b1;
        end
        r.scl_out     = eng_scl;
        r.sda_out     = eng_sda;
        r.busy_res    = (eng_phase != PH_IDLE);
        r.done_res    = finished;
        r.read_data   = eng_rx;
        r.ack_missing = eng_nack;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Gap lengths: mostly none, often short, rarely a long pause; none while idling is clear.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic line_level(input t_sda_mode mode);
        case (mode)
            SDA_HIGH:        return 1'b1;
            SDA_LOW:         return 1'b0;
            SDA_MOSTLY_HIGH: return ($urandom_range(0, 7) != 0);
            default:         return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic void push_tick(input logic [KIND_W-1:0] kind,
                                      input logic [BYTE_W-1:0] data,
                                      input logic send_ack, input logic sda);
        t_bus_tick t;
        t.kind     = kind;
        t.data     = data;
        t.send_ack = send_ack;
        t.sda_in   = sda;
        pending_ticks.push_back(t);
    endfunction

    // Plain ticks that carry a command along. With noisy set, a few of them
    // carry random kinds, which the engine must ignore while it is busy.
    function automatic void push_idle(input int count, input t_sda_mode mode,
                                      input bit noisy);
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < count; i++) begin
            kind = KIND_TICK;
            if (noisy && $urandom_range(0, 11) == 0) begin
                kind = KIND_W'($urandom_range(0, int'(KIND_TOP)));
            end
            push_tick(kind, BYTE_W'($urandom), 1'($urandom), line_level(mode));
        end
    endfunction

    // Queues a command tick followed by enough ticks to carry it through all
    // its bus phases, plus a little slack. A clipped command gets fewer, so
    // the next command may land while the engine is still busy.
    function automatic void queue_command(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] data,
                                          input logic send_ack, input t_sda_mode mode,
                                          input bit noisy, input bit clipped);
        int phases;
        int span;
        case (kind)
            KIND_WRITE: phases = 17 + ((cfg_polls == '0) ? 1 : int'(cfg_polls));
            KIND_READ:  phases = 18;
            default:    phases = 2;
        endcase
        span = phases * ((cfg_half == '0) ? 1 : int'(cfg_half)) + $urandom_range(0, 3);
        if (clipped) span = $urandom_range(0, span);
        push_tick(kind, data, send_ack, line_level(mode));
        push_idle(span, mode, noisy);
    endfunction

    // Register writes happen only here, and only while the engine is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do @(posedge i_clk); while (!reg_if.ready);
        reg_if.valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD) begin
            cfg_half = val;
        end else if (idx == CFG_ACK_POLL) begin
            cfg_polls = val[POLL_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Keeps feeding plain ticks until the shadow engine is idle, then waits
    // until every tick has been taken and every result has come back, and
    // then lets the pipeline settle.
    task automatic drain_engine();
        while (eng_phase != PH_IDLE || pending_ticks.size() != 0 ||
               expected_bus.size() != 0 || tick_if.valid) begin
            if (eng_phase != PH_IDLE && pending_ticks.size() == 0) begin
                push_tick(KIND_TICK, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
            end
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tick driver: offers the pending ticks one by one. A tick counts as
    // taken at the edge where valid and ready are both high; the shadow
    // engine steps on that same transfer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                expected_bus.push_back(predict_tick(offered_tick));
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tick_if.valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    offered_tick = pending_ticks.pop_front();
                    tick_if.kind     <= offered_tick.kind;
                    tick_if.data     <= offered_tick.data;
                    tick_if.send_ack <= offered_tick.send_ack;
                    tick_if.sda_in   <= offered_tick.sda_in;
                    tick_if.valid    <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every result transfer is matched against the oldest
    // expected bus result. Ready is dropped for random stretches.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_bus.size() == 0) begin
                    $error("bus result arrived with no accepted tick outstanding");
                    mismatches++;
                end else begin
                    want = expected_bus.pop_front();
                    check_field("scl_out", BYTE_W'(want.scl_out), BYTE_W'(res_if.scl_out));
                    check_field("sda_out", BYTE_W'(want.sda_out), BYTE_W'(res_if.sda_out));
                    check_field("busy_res", BYTE_W'(want.busy_res),
                                BYTE_W'(res_if.busy_res));
                    check_field("done_res", BYTE_W'(want.done_res),
                                BYTE_W'(res_if.done_res));
                    check_field("read_data", want.read_data, res_if.read_data);
                    check_field("ack_missing", BYTE_W'(want.ack_missing),
                                BYTE_W'(res_if.ack_missing));
                end
                sink_stall = pick_gap();
            end
            if (sink_stall > 0) begin
                sink_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                cmds;
        int                r;
        logic [KIND_W-1:0] kind;

        // Every input is known from time zero on.
        i_rst_n          = 1'b0;
        tick_if.valid    = 1'b0;
        tick_if.kind     = KIND_TICK;
        tick_if.data     = '0;
        tick_if.send_ack = 1'b0;
        tick_if.sda_in   = 1'b1;
        res_if.ready     = 1'b0;
        reg_if.valid     = 1'b0;
        reg_if.index     = CFG_HALF_PERIOD;
        reg_if.data      = '0;
        mismatches       = 0;
        cycle_count      = 0;
        idling           = 1'b1;

        // Shadow engine after reset.
        cfg_half       = HALF_PERIOD_RESET;
        cfg_polls      = ACK_POLL_RESET;
        eng_phase      = PH_IDLE;
        eng_bits       = '0;
        eng_shift      = '0;
        eng_rx         = '0;
        eng_wait       = '0;
        eng_polls      = '0;
        eng_scl        = 1'b1;
        eng_sda        = 1'b1;
        eng_ack_choice = 1'b0;
        eng_nack       = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings. Idle ticks and unused kinds
        // must start nothing.
        push_tick(KIND_TICK, 8'hFF, 1'b1, 1'b0);
        push_tick(KIND_READ + 3'd1, 8'h00, 1'b0, 1'b1);
        push_tick(KIND_READ + 3'd2, 8'h55, 1'b1, 1'b0);
        push_tick(KIND_TOP, 8'hAA, 1'b0, 1'b1);
        queue_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 1'b0);
        // Commands right behind a start are ignored while it runs.
        push_tick(KIND_START, 8'h00, 1'b0, 1'b1);
        push_tick(KIND_WRITE, 8'h3C, 1'b0, 1'b1);
        push_tick(KIND_READ, 8'h00, 1'b1, 1'b0);
        push_tick(KIND_STOP, 8'h00, 1'b0, 1'b1);
        push_idle(2 * int'(cfg_half) + 2, SDA_RANDOM, 1'b0);
        drain_engine();

        // Byte commands with short phases and the reset poll limit.
        write_reg(CFG_HALF_PERIOD, 16'd1);
        // Acknowledged on the first poll, then one that never gets an
        // acknowledge, then one with SDA mostly high, acknowledged late or not at all.
        queue_command(KIND_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0, 1'b0);
        queue_command(KIND_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0, 1'b0);
        queue_command(KIND_WRITE, 8'hA5, 1'b1, SDA_MOSTLY_HIGH, 1'b0, 1'b0);
        // Reads of all ones and all zeros, with ACK and with NACK.
        queue_command(KIND_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0, 1'b0);
        queue_command(KIND_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0, 1'b0);
        queue_command(KIND_READ, BYTE_W'($urandom), 1'b1, SDA_RANDOM, 1'b0, 1'b0);
        drain_engine();

        // Shortest phases and a single acknowledge sample.
        write_reg(CFG_ACK_POLL, 16'd1);
        queue_command(KIND_WRITE, 8'h80, 1'b0, SDA_HIGH, 1'b0, 1'b0);
        queue_command(KIND_WRITE, 8'h01, 1'b1, SDA_LOW, 1'b0, 1'b0);
        drain_engine();

        // Zero settings behave as one tick and one sample.
        write_reg(CFG_HALF_PERIOD, 16'd0);
        write_reg(CFG_ACK_POLL, 16'd0);
        queue_command(KIND_WRITE, 8'h5A, 1'b0, SDA_HIGH, 1'b0, 1'b0);
        queue_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(KIND_READ, BYTE_W'($urandom), 1'b0, SDA_RANDOM, 1'b0, 1'b0);
        drain_engine();

        // Random part: mostly complete commands with random payload and SDA
        // behavior, with stray ticks, busy-time commands and cut-short
        // commands mixed in. Each block runs with its own settings.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_HALF_PERIOD, 16'd1);
                    write_reg(CFG_ACK_POLL, 16'd15);
                end
                1: begin
                    write_reg(CFG_HALF_PERIOD, 16'd2);
                    write_reg(CFG_ACK_POLL, CFG_DATA_W'($urandom_range(1, 14)));
                end
                2: begin
                    write_reg(CFG_HALF_PERIOD, CFG_DATA_W'($urandom_range(1, 2)));
                    write_reg(CFG_ACK_POLL, CFG_DATA_W'($urandom_range(0, 15)));
                end
                default: begin
                    write_reg(CFG_HALF_PERIOD, CFG_DATA_W'($urandom_range(1, 2)));
                    write_reg(CFG_ACK_POLL, 16'd1);
                end
            endcase
            idling = ($urandom_range(0, 3) != 0);
            cmds = 0;
            while (cmds < CMDS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    repeat ($urandom_range(1, 3)) begin
                        kind = ($urandom_range(0, 3) == 0) ? KIND_TICK :
                               KIND_W'($urandom_range(int'(KIND_READ) + 1, int'(KIND_TOP)));
                        push_tick(kind, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                    end
                end else begin
                    r = $urandom_range(0, 19);
                    if (r < 3) kind = KIND_START;
                    else if (r < 6) kind = KIND_STOP;
                    else if (r < 13) kind = KIND_WRITE;
                    else kind = KIND_READ;
                    queue_command(kind, BYTE_W'($urandom), 1'($urandom),
                                  t_sda_mode'($urandom_range(0, 3)),
                                  $urandom_range(0, 3) == 0, $urandom_range(0, 19) == 0);
                    cmds++;
                end
            end
            drain_engine();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- i2c_master_bit_engine.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_bit_engine.sv
hw/rtl/i2cm_checker.sv
bench/tb_top.sv
